// ===== design/gps_pkg.sv =====
// Shared types, mode codes and helpers for the graphics pixel sequencer.
package gps_pkg;

  // Display mode bits
  localparam int ModeBitEcm = 2;
  localparam int ModeBitBmm = 1;
  localparam int ModeBitMcm = 0;

  localparam logic [2:0] MODE_STD_TEXT  = 3'd0;
  localparam logic [2:0] MODE_MC_TEXT   = 3'd1;
  localparam logic [2:0] MODE_BITMAP    = 3'd2;
  localparam logic [2:0] MODE_MC_BITMAP = 3'd3;
  localparam logic [2:0] MODE_ECM_TEXT  = 3'd4;

  // Color nibble bit that marks a multicolor character
  localparam int ColorMcBit = 3;
  localparam logic [3:0] MC_TEXT_FG_MASK = 4'h7;

  typedef struct packed {
    logic [2:0]  pixel_index;
    logic [2:0]  xscroll;
    logic [2:0]  mode;
    logic        mc_generate;
    logic        flop_clear;
    logic        load_allowed;
    logic [7:0]  gfx_pixels;
    logic [7:0]  gfx_char;
    logic [3:0]  gfx_color;
    logic [15:0] bg_colors;
  } pixel_beat_t;

  typedef struct packed {
    logic [3:0] pixel_color;
    logic       is_foreground;
  } color_beat_t;

  // What the sequencer stage hands to the color stage
  typedef struct packed {
    logic        valid;
    logic [2:0]  mode;
    logic [15:0] bg_colors;
    logic [1:0]  color_bits;
    logic [7:0]  latched_char;
    logic [3:0]  latched_color;
  } stage_t;

  function automatic logic [3:0] bg_pick(input logic [15:0] bg, input logic [1:0] idx);
    logic [3:0] res;
    case (idx)
      2'd0:    res = bg[3:0];
      2'd1:    res = bg[7:4];
      2'd2:    res = bg[11:8];
      default: res = bg[15:12];
    endcase
    return res;
  endfunction

  // Multicolor display: MCM set and either bitmap or a multicolor character
  function automatic logic mc_display(input logic [2:0] mode, input logic mcbit);
    return mode[ModeBitMcm] & (mode[ModeBitBmm] | mcbit);
  endfunction

endpackage

// ===== design/gps_shifter.sv =====
// Shift register, character latches and multicolor flip-flop, updated once per beat.
module gps_shifter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 advance,
  input  gps_pkg::pixel_beat_t pixel,
  output gps_pkg::stage_t      stage
);

  logic [7:0] shift_data;
  logic [7:0] latched_char;
  logic [3:0] latched_color;
  logic       mc_flop;
  logic [1:0] color_bits;
  logic       valid;
  logic [2:0] mode;
  logic [15:0] bg_colors;

  logic       load;
  logic       flop_pre;
  logic       flop_ld;
  logic [7:0] shift_ld;
  logic [3:0] color_ld;
  logic       mcbit;
  logic       mc_disp;
  logic       mc_gen;
  logic [1:0] color_bits_next;

  always_comb begin
    load     = (pixel.pixel_index == pixel.xscroll) && pixel.load_allowed;
    flop_pre = pixel.flop_clear ? 1'b0 : mc_flop;
    flop_ld  = load ? 1'b1 : flop_pre;
    shift_ld = load ? pixel.gfx_pixels : shift_data;
    color_ld = load ? pixel.gfx_color : latched_color;
    mcbit    = color_ld[gps_pkg::ColorMcBit];
    mc_disp  = gps_pkg::mc_display(pixel.mode, mcbit);
    mc_gen   = pixel.mc_generate & (pixel.mode[gps_pkg::ModeBitBmm] | mcbit);
    if (mc_gen) begin
      if (flop_ld) begin
        color_bits_next = mc_disp ? shift_ld[7:6] : {1'b0, shift_ld[7]};
      end else begin
        color_bits_next = color_bits;
      end
    end else begin
      color_bits_next = mc_disp ? {shift_ld[7], 1'b0} : {1'b0, shift_ld[7]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_data    <= '0;
      latched_char  <= '0;
      latched_color <= '0;
      mc_flop       <= 1'b0;
      color_bits    <= '0;
      valid         <= 1'b0;
    end else begin
      if (accept) begin
        shift_data    <= {shift_ld[6:0], 1'b0};
        latched_char  <= load ? pixel.gfx_char : latched_char;
        latched_color <= color_ld;
        mc_flop       <= ~flop_ld;
        color_bits    <= color_bits_next;
        valid         <= 1'b1;
      end else if (advance) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode      <= pixel.mode;
      bg_colors <= pixel.bg_colors;
    end
  end

  always_comb begin
    stage.valid         = valid;
    stage.mode          = mode;
    stage.bg_colors     = bg_colors;
    stage.color_bits    = color_bits;
    stage.latched_char  = latched_char;
    stage.latched_color = latched_color;
  end

endmodule

// ===== design/gps_colorsel.sv =====
// Mode-dependent color select and the result register.
module gps_colorsel (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 take,
  input  gps_pkg::stage_t      stage,
  output logic                 color_valid,
  output gps_pkg::color_beat_t color
);

  logic [3:0] color_sel;
  logic       fg_sel;
  logic       mcbit;
  logic [1:0] cb;

  always_comb begin
    cb    = stage.color_bits;
    mcbit = stage.latched_color[gps_pkg::ColorMcBit];
    case (stage.mode)
      gps_pkg::MODE_STD_TEXT: begin
        color_sel = cb[0] ? stage.latched_color : gps_pkg::bg_pick(stage.bg_colors, 2'd0);
      end
      gps_pkg::MODE_MC_TEXT: begin
        if (!mcbit) begin
          color_sel = cb[0] ? stage.latched_color : gps_pkg::bg_pick(stage.bg_colors, 2'd0);
        end else if (cb == 2'd3) begin
          color_sel = stage.latched_color & gps_pkg::MC_TEXT_FG_MASK;
        end else begin
          color_sel = gps_pkg::bg_pick(stage.bg_colors, cb);
        end
      end
      gps_pkg::MODE_BITMAP: begin
        color_sel = cb[0] ? stage.latched_char[7:4] : stage.latched_char[3:0];
      end
      gps_pkg::MODE_MC_BITMAP: begin
        case (cb)
          2'd0:    color_sel = gps_pkg::bg_pick(stage.bg_colors, 2'd0);
          2'd1:    color_sel = stage.latched_char[7:4];
          2'd2:    color_sel = stage.latched_char[3:0];
          default: color_sel = stage.latched_color;
        endcase
      end
      gps_pkg::MODE_ECM_TEXT: begin
        color_sel = cb[0] ? stage.latched_color
                          : gps_pkg::bg_pick(stage.bg_colors, stage.latched_char[7:6]);
      end
      default: color_sel = 4'd0;  // illegal ECM combinations draw black
    endcase
    fg_sel = gps_pkg::mc_display(stage.mode, mcbit) ? cb[1] : (cb != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (advance) begin
      color_valid <= 1'b1;
    end else if (take) begin
      color_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      color.pixel_color   <= color_sel;
      color.is_foreground <= fg_sel;
    end
  end

endmodule

// ===== design/graphics_pixel_sequencer_unit.sv =====
// Top level of the graphics pixel sequencer: sequencer stage plus color stage.
// An accepted pixel beat passes the sequencer stage registers, then the result register.
// Throughput: one pixel per cycle while pixel_stall is low; the shift register, latches and flip-flop
//   update in the accept cycle, so the next pixel can follow at once.
// pixel_stall rises only when both stages hold beats and color_stall is high.
// Synchronous reset clears shift register, latches, flip-flop, color bits and valids.
module graphics_pixel_sequencer_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  gps_pkg::pixel_beat_t pixel,
  output logic                 color_valid,
  input  logic                 color_stall,
  output gps_pkg::color_beat_t color
);

  gps_pkg::stage_t stage;
  logic            out_free;  // result register can load this cycle
  logic            advance;   // sequencer stage moves into result register
  logic            accept;
  logic            take;

  // Result register empties on a taken beat, so the stage behind it moves.
  assign take        = color_valid & ~color_stall;
  assign out_free    = ~color_valid | ~color_stall;
  assign advance     = stage.valid & out_free;
  // Stage can take a new pixel when empty or emptying this cycle.
  assign pixel_stall = stage.valid & ~out_free;
  assign accept      = pixel_valid & ~pixel_stall;

  gps_shifter u_shifter (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .advance (advance),
    .pixel   (pixel),
    .stage   (stage)
  );

  gps_colorsel u_colorsel (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .take        (take),
    .stage       (stage),
    .color_valid (color_valid),
    .color       (color)
  );

endmodule

// ===== design/gps_checker.sv =====
// Port-level checker for the graphics pixel sequencer, bound to the top level.
module gps_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 pixel_valid,
  input logic                 pixel_stall,
  input logic                 color_valid,
  input logic                 color_stall,
  input gps_pkg::color_beat_t color
);

  // A pending color beat is not withdrawn while stalled.
  assert property (@(posedge clk) disable iff (rst)
    color_valid && color_stall |=> color_valid)
    else $error("color beat dropped under stall");

  // A stalled color beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    color_valid && color_stall |=> $stable(color))
    else $error("color payload changed under stall");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !color_valid)
    else $error("color beat after reset");

  // Every accepted pixel is followed by a valid color beat once through the sequencer stage and result register.
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall |=> ##1 color_valid)
    else $error("accepted pixel produced no color beat");

  // Input backpressure only when a result is waiting.
  assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> color_valid && color_stall)
    else $error("input stalled with free result register");

endmodule

bind graphics_pixel_sequencer_unit gps_checker u_gps_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .color_valid (color_valid),
  .color_stall (color_stall),
  .color       (color)
);
